// ===== sv/asns_pkg.sv =====
// shared types, phase codes and nibble order for the analog stick serializer
package asns_pkg;

	localparam int unsigned FRAME_NIBBLES = 12;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_RESET = 2'd1;
	localparam logic [1:0] PH_FRAME = 2'd2;

	localparam logic KIND_COM  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [7:0] IDLE_BYTE  = 8'hFF;
	localparam logic [7:0] RESET_BYTE = 8'h0F;

	// nibble slots within a frame
	localparam logic [3:0] NIB_BTN_HI = 4'd0;
	localparam logic [3:0] NIB_BTN_LO = 4'd1;
	localparam logic [3:0] NIB_Y_HI   = 4'd2;
	localparam logic [3:0] NIB_X_HI   = 4'd3;
	localparam logic [3:0] NIB_THR_HI = 4'd4;
	localparam logic [3:0] NIB_Y_LO   = 4'd6;
	localparam logic [3:0] NIB_X_LO   = 4'd7;
	localparam logic [3:0] NIB_THR_LO = 4'd8;

	typedef struct packed {
		logic       kind;
		logic       com_level;
		logic [7:0] buttons;
		logic [7:0] stick_x;
		logic [7:0] stick_y;
		logic [7:0] throttle;
	} item_t;

endpackage

// ===== sv/asns_core.sv =====
// phase state and nibble select, one item per step
module asns_core import asns_pkg::*; #(
	parameter int unsigned FRAME_SIZE = FRAME_NIBBLES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  item_t      item,
	output logic [7:0] data
);

	localparam logic [3:0] FRAME_LAST = 4'(FRAME_SIZE);

	logic [1:0] phase_q;
	logic [3:0] count_q;
	logic       strobe_q;
	logic       ack_q;
	logic       last_com_q;
	logic [3:0] nib;
	logic [3:0] count_inc;

	always_comb begin
		case (count_q)
			NIB_BTN_HI: nib = item.buttons[7:4];
			NIB_BTN_LO: nib = item.buttons[3:0];
			NIB_Y_HI:   nib = item.stick_y[7:4];
			NIB_X_HI:   nib = item.stick_x[7:4];
			NIB_THR_HI: nib = item.throttle[7:4];
			NIB_Y_LO:   nib = item.stick_y[3:0];
			NIB_X_LO:   nib = item.stick_x[3:0];
			NIB_THR_LO: nib = item.throttle[3:0];
			default:    nib = 4'd0;
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_RESET: data = RESET_BYTE;
			PH_FRAME: data = {2'b00, ack_q, strobe_q, nib};
			default:  data = IDLE_BYTE;
		endcase
	end

	assign count_inc = count_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= 4'd0;
			strobe_q   <= 1'b0;
			ack_q      <= 1'b0;
			last_com_q <= 1'b0;
		end else if (step_en) begin
			if (item.kind == KIND_COM) begin
				last_com_q <= item.com_level;
				if (!item.com_level) begin
					phase_q <= PH_RESET;
				end else if (phase_q == PH_RESET) begin
					phase_q  <= PH_FRAME;
					count_q  <= 4'd0;
					strobe_q <= 1'b1;
					ack_q    <= 1'b0;
				end
			end else if (phase_q == PH_FRAME) begin
				ack_q <= ~ack_q;
				if (ack_q) begin
					strobe_q <= ~strobe_q;
					count_q  <= count_inc;
					// frame done, or the count wrapped
					if (count_inc >= FRAME_LAST || count_inc == 4'd0) begin
						phase_q <= PH_IDLE;
					end
				end
			end
		end
	end

`ifndef SYNTH
	a_count_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FRAME) |-> (count_q < FRAME_LAST))
		else $error("nibble count past frame end");

	a_com_low_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && item.kind == KIND_COM && !item.com_level) |=> (phase_q == PH_RESET))
		else $error("com low did not enter reset phase");

	a_ack_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && item.kind == KIND_READ && phase_q == PH_FRAME && !ack_q)
		|=> (ack_q && phase_q == PH_FRAME && $stable(count_q)))
		else $error("first read of a pair advanced the frame");

	a_last_com: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && item.kind == KIND_COM) |=> (last_com_q == $past(item.com_level)))
		else $error("com level not recorded");
`endif

endmodule

// ===== sv/asns_rsp_reg.sv =====
// result register on the response side
module asns_rsp_reg import asns_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [7:0] load_data,
	output logic       load_ok,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] rsp_byte
);

	logic       valid_q;
	logic [7:0] data_q;

	assign load_ok   = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp_byte  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

// ===== sv/analog_stick_nibble_serializer.sv =====
// top level: analog stick nibble serializer for a game port
// a read item's byte passes the input register and then the result register to rsp_byte, held until taken
// one item per cycle while req_stall is low; the input register and the result register
//   keep the pipe full while the response side keeps taking items
// reset: arst_n clears the phase to idle, count, strobe, ack, last com and all valid flags
module analog_stick_nibble_serializer import asns_pkg::*; #(
	parameter int unsigned FRAME_SIZE = FRAME_NIBBLES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       kind,
	input  logic       com_level,
	input  logic [7:0] buttons,
	input  logic [7:0] stick_x,
	input  logic [7:0] stick_y,
	input  logic [7:0] throttle,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] rsp_byte
);

	// accepted item waiting for its step
	logic  valid_s1;
	item_t item_s1;

	logic       adv_s1;    // item in s1 steps the state this cycle
	logic       load_ok;   // result register can take a byte
	logic       accept;
	logic [7:0] step_data;

	// a com write never needs the result register, a read does
	assign adv_s1    = valid_s1 && (item_s1.kind == KIND_COM || load_ok);
	assign req_stall = valid_s1 && !adv_s1;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{kind: kind, com_level: com_level, buttons: buttons,
				stick_x: stick_x, stick_y: stick_y, throttle: throttle};
		end
	end

	// phase state machine and nibble select
	asns_core #(
		.FRAME_SIZE (FRAME_SIZE)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv_s1),
		.item    (item_s1),
		.data    (step_data)
	);

	// result register decouples the response stall from the state update
	asns_rsp_reg u_rsp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv_s1 && item_s1.kind == KIND_READ),
		.load_data (step_data),
		.load_ok   (load_ok),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_byte  (rsp_byte)
	);

`ifndef SYNTH
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !req_stall)
		else $error("stall with empty input register");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("blocked item lost");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_byte)))
		else $error("stalled result changed");
`endif

endmodule
